@@ sv/src_pkg.sv @@
// Shared types and codes for the sorted rank counter.
`default_nettype none

package src_pkg;

    localparam int RANK_W = 11;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRD,
        ST_SCMP,
        ST_SHRD,
        ST_SHWR,
        ST_INS,
        ST_QDONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic              overflow;
    } t_result;

endpackage

`default_nettype wire

@@ sv/src_engine.sv @@
// Sorted value store with binary search and insertion shift engine.
`default_nettype none

module src_engine #(
    parameter int CAPACITY = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [1:0]      i_kind,
    input  wire logic [31:0]     i_value,
    input  wire logic            i_res_ready,
    output logic                 o_busy,
    output src_pkg::t_result     o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0] mem [CAPACITY];

    src_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_mid, n_mid;
    logic [AW-1:0]   r_idx, n_idx;
    logic [31:0]     r_key, n_key;
    logic            r_load, n_load;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [31:0]     r_rdata;

    logic [CW-1:0]   mid_c;
    logic [CW-1:0]   cnt_m1;
    logic            full;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;
    logic            we;
    logic [CW+src_pkg::RANK_W-1:0] lo_ext;

    assign mid_c  = r_lo + ((r_hi - r_lo) >> 1);
    assign cnt_m1 = r_count - CW'(1);
    assign full   = (r_count == CW'(CAPACITY));
    assign lo_ext = {{src_pkg::RANK_W{1'b0}}, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= src_pkg::ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_load  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_load  <= n_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_idx <= n_idx;
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_idx   = r_idx;
        n_key   = r_key;
        n_load  = r_load;
        n_count = r_count;
        n_ovf   = r_ovf;
        case (r_state)
            src_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        src_pkg::KIND_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        src_pkg::KIND_LOAD: begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_key   = i_value;
                                n_load  = 1'b1;
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_state = (r_count != '0) ? src_pkg::ST_SRD : src_pkg::ST_INS;
                            end
                        end
                        src_pkg::KIND_QUERY: begin
                            n_key   = i_value;
                            n_load  = 1'b0;
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = (r_count != '0) ? src_pkg::ST_SRD : src_pkg::ST_QDONE;
                        end
                        default: ;
                    endcase
                end
            end
            src_pkg::ST_SRD: begin
                n_mid   = mid_c;
                n_state = src_pkg::ST_SCMP;
            end
            src_pkg::ST_SCMP: begin
                if (r_rdata <= r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                if (n_lo < n_hi) begin
                    n_state = src_pkg::ST_SRD;
                end else if (!r_load) begin
                    n_state = src_pkg::ST_QDONE;
                end else if (r_count > n_lo) begin
                    n_idx   = cnt_m1[AW-1:0];
                    n_state = src_pkg::ST_SHRD;
                end else begin
                    n_state = src_pkg::ST_INS;
                end
            end
            src_pkg::ST_SHRD: begin
                n_state = src_pkg::ST_SHWR;
            end
            src_pkg::ST_SHWR: begin
                if (r_idx == r_lo[AW-1:0]) begin
                    n_state = src_pkg::ST_INS;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = src_pkg::ST_SHRD;
                end
            end
            src_pkg::ST_INS: begin
                n_count = r_count + CW'(1);
                n_state = src_pkg::ST_IDLE;
            end
            src_pkg::ST_QDONE: begin
                if (i_res_ready) begin
                    n_state = src_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = src_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        raddr          = mid_c[AW-1:0];
        waddr          = r_lo[AW-1:0];
        wdata          = r_key;
        we             = 1'b0;
        o_res.valid    = 1'b0;
        o_res.rank     = lo_ext[src_pkg::RANK_W-1:0];
        o_res.overflow = r_ovf;
        case (r_state)
            src_pkg::ST_SHRD: begin
                raddr = r_idx;
            end
            src_pkg::ST_SHWR: begin
                we    = 1'b1;
                waddr = r_idx + AW'(1);
                wdata = r_rdata;
            end
            src_pkg::ST_INS: begin
                we = 1'b1;
            end
            src_pkg::ST_QDONE: begin
                o_res.valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != src_pkg::ST_IDLE);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == src_pkg::ST_SCMP) |-> (r_lo < r_hi && r_mid < r_hi))
        else $error("compare outside search window");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == src_pkg::ST_SHWR) |-> ({1'b0, r_idx} + (AW+1)'(1) < (AW+1)'(r_count) + (AW+1)'(1)
            && r_count < CW'(CAPACITY)))
        else $error("shift write beyond stored entries");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == src_pkg::ST_INS) |-> !full)
        else $error("insert into full store");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == src_pkg::ST_INS) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow count");
`endif

endmodule

`default_nettype wire

@@ sv/sorted_rank_counter_top.sv @@
// Sorted rank counter: sorted store of unsigned values answering upper-bound rank queries.
// Query: each binary search step is a memory read, then a compare, up to ceil(log2(n+1)) steps
//   for n stored entries; ST_QDONE then holds the result until the output register takes it.
// Load: the same search, then a read and a write per entry moved up, then the insert write.
// Clear and dropped loads stay in idle. One item at a time; the result register frees the engine.
// Reset (synchronous, active low) empties the set and drops overflow; the store is not cleared.
`default_nettype none

module sorted_rank_counter_top #(
    parameter int CAPACITY = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [10:0] rank, [11] overflow, [15:12] zero
);

    src_pkg::t_result res;
    logic             busy;
    logic             slot_free;
    logic             r_mvalid;
    logic [15:0]      r_mdata;

    assign slot_free     = !r_mvalid || m_axis_tready;
    assign s_axis_tready = !busy;

    src_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid && s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_res_ready (slot_free),
        .o_busy      (busy),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (slot_free) begin
            r_mvalid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && res.valid) begin
            r_mdata <= {4'b0, res.overflow, res.rank};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

`default_nettype wire

@@ dv/tb_sorted_rank_counter_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted rank counter: directed table, then random traffic.
module tb_sorted_rank_counter_top;

    localparam int CAPACITY     = 1024;
    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int END_WAIT     = 2 * CAPACITY + 64;
    localparam int RANK_W       = src_pkg::RANK_W;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              overflow;
    } rank_res_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        typed;
        rank_res_t   res;
    } dir_row_t;

    localparam int DIR_N = 22;
    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        '{src_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, '{11'd0, 1'b0}},
        '{KIND_UNUSED,         32'hA5A5_A5A5, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_LOAD,  32'hFFFF_FFFF, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_LOAD,  32'h0000_0000, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_LOAD,  32'h0000_0005, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_LOAD,  32'h0000_0005, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h0000_0000, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h0000_0004, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h0000_0005, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'hFFFF_FFFE, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, '{11'd4, 1'b0}},
        '{KIND_UNUSED,         32'hFFFF_FFFF, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h0000_0006, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_CLEAR, 32'h0000_0000, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b1, '{11'd0, 1'b0}},
        '{src_pkg::KIND_LOAD,  32'h8000_0000, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_LOAD,  32'h7FFF_FFFF, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h7FFF_FFFF, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h8000_0000, 1'b0, '{11'd0, 1'b0}},
        '{src_pkg::KIND_QUERY, 32'h0000_0000, 1'b1, '{11'd0, 1'b0}},
        '{src_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 1'b0, '{11'd0, 1'b0}}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;

    // mirror of the sorted store
    logic [31:0] held_vals [CAPACITY];
    int          held_count = 0;
    logic        held_ovf   = 1'b0;
    rank_res_t   rank_q [$];

    bit no_idle   = 1'b0;
    bit sink_free = 1'b0;
    int sink_hold = 0;
    int cycles    = 0;
    int errors    = 0;
    int live_items   = 0;
    int loads_sent   = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int ovf_results  = 0;
    int peak_rank    = 0;

    sorted_rank_counter_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value
        .s_axis_tuser  (s_axis_tuser),   // [1:0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [10:0] rank, [11] overflow, [15:12] zero
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int upper_rank_of(logic [31:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_count;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (held_vals[mid] <= key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    task automatic predict_item(input logic [1:0] kind, input logic [31:0] value,
                                output bit has_res, output rank_res_t res);
        int pos;
        int i;
        has_res = 1'b0;
        res     = '0;
        case (kind)
            src_pkg::KIND_CLEAR: begin
                held_count = 0;
                held_ovf   = 1'b0;
            end
            src_pkg::KIND_LOAD: begin
                if (held_count >= CAPACITY) begin
                    held_ovf = 1'b1;
                end else begin
                    pos = upper_rank_of(value);
                    for (i = held_count; i > pos; i--) begin
                        held_vals[i] = held_vals[i-1];
                    end
                    held_vals[pos] = value;
                    held_count++;
                end
            end
            src_pkg::KIND_QUERY: begin
                has_res      = 1'b1;
                res.rank     = RANK_W'(upper_rank_of(value));
                res.overflow = held_ovf;
            end
            default: begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stored values and their neighbours hit the rank boundaries
    function automatic logic [31:0] pick_value();
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        if (held_count != 0 && r < 4) begin
            v = held_vals[$urandom_range(0, held_count - 1)];
            r = $urandom_range(0, 2);
            if (r == 1) begin
                v = v - 1;
            end else if (r == 2) begin
                v = v + 1;
            end
        end else if (r == 4) begin
            v = '0;
        end else if (r == 5) begin
            v = '1;
        end else if (r == 6) begin
            v = $urandom_range(0, 15);
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [31:0] value,
                             input bit typed, input rank_res_t typed_res);
        int        gap;
        bit        has_res;
        rank_res_t res;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(kind, value, has_res, res);
        if (has_res) begin
            rank_q.push_back(typed ? typed_res : res);
        end
        if (kind != KIND_UNUSED) live_items++;
        if (kind == src_pkg::KIND_LOAD) loads_sent++;
        if (kind == src_pkg::KIND_QUERY) queries_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (rank_q.size() != 0);
    endtask

    task automatic run_small_segment();
        int          n;
        int          r;
        logic [31:0] v;
        no_idle   = ($urandom_range(0, 4) == 0);
        sink_free = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) wait_drained();
        if (held_count > 48 || $urandom_range(0, 1) == 0) begin
            send_item(src_pkg::KIND_CLEAR, $urandom(), 1'b0, '0);
        end
        n = $urandom_range(1, 30);
        repeat (n) begin
            r = $urandom_range(0, 99);
            v = pick_value();
            if (r < 50) begin
                send_item(src_pkg::KIND_LOAD, v, 1'b0, '0);
            end else if (r < 92) begin
                send_item(src_pkg::KIND_QUERY, v, 1'b0, '0);
            end else if (r < 96) begin
                send_item(KIND_UNUSED, v, 1'b0, '0);
            end else begin
                send_item(src_pkg::KIND_CLEAR, v, 1'b0, '0);
            end
        end
    endtask

    // ascending loads keep insertion shifts short while filling to capacity
    task automatic run_fill_segment();
        logic [31:0] v;
        no_idle   = 1'b0;
        sink_free = 1'b0;
        wait_drained();
        send_item(src_pkg::KIND_CLEAR, $urandom(), 1'b0, '0);
        v = $urandom_range(0, 1000);
        while (held_count < CAPACITY) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(src_pkg::KIND_QUERY, pick_value(), 1'b0, '0);
            end else begin
                if ($urandom_range(0, 7) != 0) begin
                    if (v > 32'hFF7F_FFFF) begin
                        v = '1;
                    end else begin
                        v = v + $urandom_range(0, 32'h0080_0000);
                    end
                end
                send_item(src_pkg::KIND_LOAD, v, 1'b0, '0);
            end
        end
        send_item(src_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b0, '0);
        repeat (4) send_item(src_pkg::KIND_LOAD, $urandom(), 1'b0, '0);
        send_item(src_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b0, '0);
        send_item(src_pkg::KIND_QUERY, 32'h0000_0000, 1'b0, '0);
        repeat (12) send_item(src_pkg::KIND_QUERY, pick_value(), 1'b0, '0);
        send_item(KIND_UNUSED, $urandom(), 1'b0, '0);
        send_item(src_pkg::KIND_LOAD, 32'h0000_0000, 1'b0, '0);
        send_item(src_pkg::KIND_QUERY, pick_value(), 1'b0, '0);
        send_item(src_pkg::KIND_CLEAR, $urandom(), 1'b0, '0);
        send_item(src_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_axis_tready && !sink_free && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold     <= $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        rank_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (rank_q.size() == 0) begin
                $error("unexpected result: rank %0d overflow %0b",
                       m_axis_tdata[10:0], m_axis_tdata[11]);
                errors++;
            end else begin
                want = rank_q.pop_front();
                if (m_axis_tdata[10:0] !== want.rank) begin
                    $error("rank: expected %0d, got %0d", want.rank, m_axis_tdata[10:0]);
                    errors++;
                end
                if (m_axis_tdata[11] !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tdata[11]);
                    errors++;
                end
                if (m_axis_tdata[15:12] !== 4'd0) begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[15:12]);
                    errors++;
                end
            end
            if (m_axis_tdata[11] === 1'b1) ovf_results++;
            if (m_axis_tdata[10:0] > peak_rank) peak_rank = m_axis_tdata[10:0];
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $error("timed out after %0d cycles, %0d results outstanding",
                   cycles, rank_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int i;
        int seg;
        int base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (i = 0; i < DIR_N; i++) begin
            send_item(DIR_TABLE[i].kind, DIR_TABLE[i].value, DIR_TABLE[i].typed,
                      DIR_TABLE[i].res);
        end
        seg  = 0;
        base = live_items;
        while (live_items - base < RANDOM_ITEMS) begin
            if (seg == 2) begin
                run_fill_segment();
            end else begin
                run_small_segment();
            end
            seg++;
        end
        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        $display("Covered %0d items (%0d loads, %0d queries), incl. a fill to capacity.",
                 live_items, loads_sent, queries_sent);
        $display("%0d results checked, %0d with overflow set, peak rank %0d.",
                 results_seen, ovf_results, peak_rank);
        if (errors == 0 && rank_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (rank_q.size() != 0) $error("%0d results never arrived", rank_q.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/src_pkg.sv
sv/src_engine.sv
sv/sorted_rank_counter_top.sv
dv/tb_sorted_rank_counter_top.sv
